// File: hw/rtl/acdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acdf_pkg
// Shared types and constants for the AEAD packet chunk deframer.
// ----------------------------------------------------------------------------
package acdf_pkg;

    // Tag length of every chunk and of the final tag
    localparam int TAG_BYTES       = 16;
    // Largest chunk size octet accepted (chunk holds 2^(octet+6) data bytes)
    localparam int MAX_CHUNK_OCTET = 16;
    // Offset and chunk-length counters must hold the largest chunk size itself
    localparam int OFS_W           = MAX_CHUNK_OCTET + 7;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 32;
    localparam int CHUNK_W = 26;
    localparam int EXP_W   = 5;

    // Header field values
    localparam logic [7:0] VERSION_V1   = 8'd1;
    localparam logic [7:0] CIPHER_A     = 8'd7;
    localparam logic [7:0] CIPHER_B     = 8'd8;
    localparam logic [7:0] CIPHER_C     = 8'd9;
    localparam logic [7:0] AEAD_EAX     = 8'd1;
    localparam logic [7:0] AEAD_OCB     = 8'd2;
    localparam logic [EXP_W-1:0] EXP_BIAS = EXP_W'(6);

    // Minimum body lengths
    localparam logic [LEN_W-1:0] MIN_BODY     = LEN_W'(37);
    localparam logic [LEN_W-1:0] MIN_BODY_EAX = LEN_W'(36);

    // IV lengths
    localparam logic [OFS_W-1:0] IV_LEN_EAX = OFS_W'(16);
    localparam logic [OFS_W-1:0] IV_LEN_OCB = OFS_W'(15);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR,
        PH_IV,
        PH_CSTART,
        PH_DATA,
        PH_TAG,
        PH_FINAL,
        PH_DISCARD
    } phase_t;

    typedef enum logic [3:0] {
        CLS_VERSION     = 4'd0,
        CLS_CIPHER      = 4'd1,
        CLS_AEAD_TYPE   = 4'd2,
        CLS_CHUNK_OCTET = 4'd3,
        CLS_IV          = 4'd4,
        CLS_CHUNK_DATA  = 4'd5,
        CLS_CHUNK_TAG   = 4'd6,
        CLS_FINAL_TAG   = 4'd7,
        CLS_DISCARD     = 4'd8
    } byte_class_t;

    typedef enum logic [2:0] {
        ERR_OK          = 3'd0,
        ERR_TOO_SHORT   = 3'd1,
        ERR_BAD_VERSION = 3'd2,
        ERR_BAD_CIPHER  = 3'd3,
        ERR_BAD_AEAD    = 3'd4,
        ERR_BIG_OCTET   = 3'd5,
        ERR_TRUNC_TAG   = 3'd6
    } err_code_t;

    typedef struct packed {
        phase_t             phase;
        logic [LEN_W-1:0]   bytes_left;
        logic               iv16;
        logic [EXP_W-1:0]   exponent;
        logic [OFS_W-1:0]   offset;
        logic [OFS_W-1:0]   dlen;
        logic [CHUNK_W-1:0] chunk;
        err_code_t          err;
    } parse_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        byte_class_t        byte_class;
        logic [CHUNK_W-1:0] chunk_number;
        logic               chunk_end;
        logic               packet_end;
        err_code_t          error_code;
    } result_t;

endpackage

// File: hw/rtl/aead_packet_chunk_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aead_packet_chunk_deframer
// Splits an AEAD packet body into header, IV, chunk data, chunk tag and
// final tag bytes, one byte per clock while m_tready holds, and flags malformed packets.
//
// Channel  Dir  Bits  Contents
// s_axis   in   40/1  tdata: data_byte[7:0], body_length[39:8]; tuser: first_byte
// m_axis   out  40/8  tdata: out_byte[7:0], chunk_number[33:8]; tuser: byte_class,
//                     chunk_end, error_code; tlast: packet_end
//
// One byte per clock sustained while m_tready stays high; each request is held in the input
// register and then in the result register. The rate holds because the parser state register
// updates once per byte, as each request moves from the input to the result register.
// While a result waits, the input register takes one more request and s_tready
// then drops; s_tready follows m_tready combinationally while both are full.
// Reset leaves the parser idle; bytes before a first byte are class discarded.
// ----------------------------------------------------------------------------
module aead_packet_chunk_deframer
    import acdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_byte[7:0], body_length[39:8]
    input  logic [0:0]  s_tuser,   // first_byte[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_byte[7:0], chunk_number[33:8], zero[39:34]
    output logic [7:0]  m_tuser,   // byte_class[3:0], chunk_end[4], error_code[7:5]
    output logic        m_tlast    // packet_end
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_first_reg;
    logic [LEN_W-1:0]  in_len_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    parse_state_t      state_reg;
    parse_state_t      state_next;
    result_t           result;
    logic              advance;

    // Move a request from the input register to the result register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Hold the input request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg  <= s_tdata[7:0];
            in_len_reg   <= s_tdata[39:8];
            in_first_reg <= s_tuser[0];
        end
    end

    acdf_classify u_classify (
        .data_byte   (in_byte_reg),
        .first_byte  (in_first_reg),
        .body_length (in_len_reg),
        .state_in    (state_reg),
        .state_next  (state_next),
        .result      (result)
    );

    // Advance the parser state once per byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= PH_IDLE;
            state_reg.bytes_left <= '0;
            state_reg.iv16       <= 1'b0;
            state_reg.exponent   <= '0;
            state_reg.offset     <= '0;
            state_reg.dlen       <= '0;
            state_reg.chunk      <= '0;
            state_reg.err        <= ERR_OK;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg.chunk_number, out_reg.out_byte};
    assign m_tuser  = {out_reg.error_code, out_reg.chunk_end, out_reg.byte_class};
    assign m_tlast  = out_reg.packet_end;

`ifndef NO_ASSERTIONS
    // A chunk ends only on a chunk tag byte
    a_chunk_end_on_tag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.chunk_end |-> out_reg.byte_class == CLS_CHUNK_TAG)
        else $error("chunk_end on a byte that is not a chunk tag");

    // An error is reported only on a header byte or a discarded byte
    a_error_class: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.error_code != ERR_OK |->
            out_reg.byte_class == CLS_VERSION || out_reg.byte_class == CLS_CIPHER ||
            out_reg.byte_class == CLS_AEAD_TYPE ||
            out_reg.byte_class == CLS_CHUNK_OCTET ||
            out_reg.byte_class == CLS_DISCARD)
        else $error("error code on a byte of a payload class");

    // The parser goes idle after the last byte of a body
    a_idle_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.packet_end |=> state_reg.phase == PH_IDLE)
        else $error("parser not idle after packet end");

    // A stalled input request stays in the input register
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input request lost while stalled");
`endif

endmodule

// File: hw/rtl/acdf_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acdf_classify
// Labels one body byte and computes the next parser state.
// ----------------------------------------------------------------------------
module acdf_classify
    import acdf_pkg::*;
(
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              first_byte,
    input  logic [LEN_W-1:0]  body_length,
    input  parse_state_t      state_in,
    output parse_state_t      state_next,
    output result_t           result
);

    parse_state_t     s;
    parse_state_t     nx;
    phase_t           ph;
    logic [LEN_W-1:0] rem;
    logic [LEN_W-1:0] diff;
    logic [OFS_W-1:0] ofs;
    logic [OFS_W-1:0] ofs1;
    logic [OFS_W-1:0] dl;
    logic [OFS_W-1:0] csize;
    logic [OFS_W-1:0] iv_len;
    logic [1:0]       sel;

    always_comb
    begin
        // Restart the parser on the first byte of a body
        s = state_in;
        if (first_byte)
        begin
            s.phase      = PH_HDR;
            s.bytes_left = body_length;
            s.iv16       = 1'b0;
            s.exponent   = '0;
            s.offset     = '0;
            s.dlen       = '0;
            s.chunk      = '0;
            s.err        = ERR_OK;
        end

        nx   = s;
        ph   = s.phase;
        rem  = s.bytes_left;
        ofs  = s.offset;
        dl   = s.dlen;
        ofs1 = '0;
        diff = '0;
        sel  = s.offset[1:0];
        iv_len = s.iv16 ? IV_LEN_EAX : IV_LEN_OCB;
        csize  = OFS_W'(1) << (s.exponent + EXP_BIAS);

        result.out_byte     = data_byte;
        result.byte_class   = CLS_DISCARD;
        result.chunk_number = '0;
        result.chunk_end    = 1'b0;
        result.packet_end   = 1'b0;
        result.error_code   = ERR_OK;

        if (s.phase != PH_IDLE)
        begin
            // Count down the body
            if (rem <= LEN_W'(1))
            begin
                result.packet_end = 1'b1;
                nx.bytes_left     = '0;
            end
            else
            begin
                nx.bytes_left = rem - LEN_W'(1);
            end

            case (s.phase)
                PH_HDR:
                begin
                    result.byte_class = byte_class_t'({2'b00, sel});
                    case (sel)
                        2'd0:
                        begin
                            if (rem < MIN_BODY)
                                result.error_code = ERR_TOO_SHORT;
                            else if (data_byte != VERSION_V1)
                                result.error_code = ERR_BAD_VERSION;
                        end
                        2'd1:
                        begin
                            if (!(data_byte inside {CIPHER_A, CIPHER_B, CIPHER_C}))
                                result.error_code = ERR_BAD_CIPHER;
                        end
                        2'd2:
                        begin
                            if (data_byte == AEAD_EAX)
                            begin
                                nx.iv16 = 1'b1;
                                if (rem < MIN_BODY_EAX)
                                    result.error_code = ERR_TOO_SHORT;
                            end
                            else if (data_byte == AEAD_OCB)
                                nx.iv16 = 1'b0;
                            else
                                result.error_code = ERR_BAD_AEAD;
                        end
                        default:
                        begin
                            if (data_byte > 8'(MAX_CHUNK_OCTET))
                                result.error_code = ERR_BIG_OCTET;
                            else
                                nx.exponent = data_byte[EXP_W-1:0];
                        end
                    endcase
                    if (sel == 2'd3)
                    begin
                        nx.phase  = PH_IV;
                        nx.offset = '0;
                    end
                    else
                    begin
                        nx.offset = s.offset + OFS_W'(1);
                    end
                end
                PH_IV:
                begin
                    result.byte_class = CLS_IV;
                    ofs1      = s.offset + OFS_W'(1);
                    nx.offset = ofs1;
                    if (ofs1 >= iv_len)
                        nx.phase = PH_CSTART;
                end
                PH_FINAL:
                begin
                    result.byte_class = CLS_FINAL_TAG;
                end
                PH_DISCARD:
                begin
                    result.byte_class = CLS_DISCARD;
                    result.error_code = s.err;
                end
                default:
                begin
                    // Chunk start: size the next chunk from what is left
                    if (s.phase == PH_CSTART)
                    begin
                        if (rem <= LEN_W'(TAG_BYTES))
                        begin
                            ph                = PH_FINAL;
                            nx.phase          = PH_FINAL;
                            result.byte_class = CLS_FINAL_TAG;
                        end
                        else if (rem < LEN_W'(2 * TAG_BYTES))
                        begin
                            result.error_code = ERR_TRUNC_TAG;
                            result.byte_class = CLS_DISCARD;
                        end
                        else
                        begin
                            diff     = rem - LEN_W'(2 * TAG_BYTES);
                            dl       = (diff > LEN_W'(csize)) ? csize : diff[OFS_W-1:0];
                            nx.dlen  = dl;
                            ofs      = '0;
                            ph       = (dl != '0) ? PH_DATA : PH_TAG;
                            nx.phase = ph;
                        end
                    end

                    // Chunk data and tag bytes
                    if (result.error_code == ERR_OK && ph == PH_DATA)
                    begin
                        result.byte_class   = CLS_CHUNK_DATA;
                        result.chunk_number = s.chunk;
                        ofs1 = ofs + OFS_W'(1);
                        if (ofs1 >= dl)
                        begin
                            nx.phase  = PH_TAG;
                            nx.offset = '0;
                        end
                        else
                        begin
                            nx.offset = ofs1;
                        end
                    end
                    else if (result.error_code == ERR_OK && ph == PH_TAG)
                    begin
                        result.byte_class   = CLS_CHUNK_TAG;
                        result.chunk_number = s.chunk;
                        ofs1 = ofs + OFS_W'(1);
                        if (ofs1 >= OFS_W'(TAG_BYTES))
                        begin
                            result.chunk_end = 1'b1;
                            nx.chunk         = s.chunk + CHUNK_W'(1);
                            nx.phase         = PH_CSTART;
                            nx.offset        = '0;
                        end
                        else
                        begin
                            nx.offset = ofs1;
                        end
                    end
                end
            endcase

            // Latch a new error and drop the rest of the packet
            if (result.error_code != ERR_OK && nx.phase != PH_DISCARD)
            begin
                nx.err   = result.error_code;
                nx.phase = PH_DISCARD;
            end
            if (result.packet_end)
                nx.phase = PH_IDLE;
        end

        state_next = nx;
    end

endmodule

// File: verif/aead_deframer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aead_deframer_checker
// Watches the input and result channels of the AEAD packet deframer, labels
// every accepted input byte with an independent parser and compares each
// result, field by field, with the oldest label still waiting.
// ----------------------------------------------------------------------------
module aead_deframer_checker
    import acdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // data_byte[7:0], body_length[39:8]
    input  logic [0:0]  s_tuser,   // first_byte[0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // out_byte[7:0], chunk_number[33:8]
    input  logic [7:0]  m_tuser,   // byte_class[3:0], chunk_end[4], error_code[7:5]
    input  logic        m_tlast,   // packet_end
    output int          mismatches,
    output int          labels_waiting
);

    // Parser state of the prediction
    phase_t             pk_phase;
    logic [LEN_W-1:0]   pk_left;
    logic [31:0]        pk_iv_len;
    logic [EXP_W-1:0]   pk_exp;
    logic [31:0]        pk_ofs;
    logic [31:0]        pk_dlen;
    logic [CHUNK_W-1:0] pk_chunk;
    err_code_t          pk_err;

    result_t            expected_labels[$];
    int                 miss_count;

    // Label one body byte and advance the parser state
    function automatic result_t label_byte(input logic [7:0] b, input logic first,
                                           input logic [31:0] len);
        result_t     r;
        err_code_t   err;
        logic [31:0] rem;
        logic [31:0] tail;
        logic [31:0] csize;
        logic [31:0] dl;
        r.out_byte     = b;
        r.byte_class   = CLS_DISCARD;
        r.chunk_number = '0;
        r.chunk_end    = 1'b0;
        r.packet_end   = 1'b0;
        r.error_code   = ERR_OK;
        err            = ERR_OK;

        // A first byte restarts the parser, even inside another packet
        if (first) begin
            pk_left   = len;
            pk_phase  = PH_HDR;
            pk_ofs    = 0;
            pk_dlen   = 0;
            pk_chunk  = '0;
            pk_err    = ERR_OK;
            pk_iv_len = 15;
            pk_exp    = '0;
        end

        // Outside a packet everything is discarded with zero side fields
        if (pk_phase == PH_IDLE)
            return r;

        rem = pk_left;
        if (rem <= 1) begin
            r.packet_end = 1'b1;
            pk_left      = 0;
        end
        else begin
            pk_left = rem - 1;
        end

        case (pk_phase)
            PH_HDR: begin
                case (pk_ofs[1:0])
                    2'd0: begin
                        r.byte_class = CLS_VERSION;
                        if (rem < MIN_BODY)
                            err = ERR_TOO_SHORT;
                        else if (b != VERSION_V1)
                            err = ERR_BAD_VERSION;
                    end
                    2'd1: begin
                        r.byte_class = CLS_CIPHER;
                        if (b != CIPHER_A && b != CIPHER_B && b != CIPHER_C)
                            err = ERR_BAD_CIPHER;
                    end
                    2'd2: begin
                        r.byte_class = CLS_AEAD_TYPE;
                        if (b == AEAD_EAX) begin
                            pk_iv_len = 16;
                            if (rem < MIN_BODY_EAX)
                                err = ERR_TOO_SHORT;
                        end
                        else if (b == AEAD_OCB) begin
                            pk_iv_len = 15;
                        end
                        else begin
                            err = ERR_BAD_AEAD;
                        end
                    end
                    default: begin
                        r.byte_class = CLS_CHUNK_OCTET;
                        if (b > MAX_CHUNK_OCTET)
                            err = ERR_BIG_OCTET;
                        else
                            pk_exp = b[EXP_W-1:0];
                    end
                endcase
                if (pk_ofs[1:0] == 2'd3) begin
                    pk_phase = PH_IV;
                    pk_ofs   = 0;
                end
                else begin
                    pk_ofs = pk_ofs + 1;
                end
            end
            PH_IV: begin
                r.byte_class = CLS_IV;
                pk_ofs       = pk_ofs + 1;
                if (pk_ofs >= pk_iv_len)
                    pk_phase = PH_CSTART;
            end
            PH_FINAL: begin
                r.byte_class = CLS_FINAL_TAG;
            end
            PH_DISCARD: begin
                r.byte_class = CLS_DISCARD;
                err          = pk_err;
            end
            default: begin
                // Size the next chunk from what is left before the final tag
                if (pk_phase == PH_CSTART) begin
                    if (rem <= TAG_BYTES) begin
                        pk_phase     = PH_FINAL;
                        r.byte_class = CLS_FINAL_TAG;
                    end
                    else begin
                        tail = rem - TAG_BYTES;
                        if (tail < TAG_BYTES) begin
                            err          = ERR_TRUNC_TAG;
                            r.byte_class = CLS_DISCARD;
                        end
                        else begin
                            // Exponent never exceeds the octet limit, so no wrap
                            csize = 32'd1 << (pk_exp + 6);
                            dl    = tail - TAG_BYTES;
                            if (dl > csize)
                                dl = csize;
                            pk_dlen  = dl;
                            pk_ofs   = 0;
                            pk_phase = (dl != 0) ? PH_DATA : PH_TAG;
                        end
                    end
                end
                if (err == ERR_OK && pk_phase == PH_DATA) begin
                    r.byte_class   = CLS_CHUNK_DATA;
                    r.chunk_number = pk_chunk;
                    pk_ofs         = pk_ofs + 1;
                    if (pk_ofs >= pk_dlen) begin
                        pk_phase = PH_TAG;
                        pk_ofs   = 0;
                    end
                end
                else if (err == ERR_OK && pk_phase == PH_TAG) begin
                    r.byte_class   = CLS_CHUNK_TAG;
                    r.chunk_number = pk_chunk;
                    pk_ofs         = pk_ofs + 1;
                    if (pk_ofs >= TAG_BYTES) begin
                        r.chunk_end = 1'b1;
                        pk_chunk    = pk_chunk + 1'b1;
                        pk_phase    = PH_CSTART;
                        pk_ofs      = 0;
                    end
                end
            end
        endcase

        // Latch the first error and drop the rest of the packet
        if (err != ERR_OK && pk_phase != PH_DISCARD) begin
            pk_err   = err;
            pk_phase = PH_DISCARD;
        end
        if (r.packet_end)
            pk_phase = PH_IDLE;

        r.error_code = err;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            miss_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Label input requests, compare result requests
    always @(posedge clk or negedge rst_n) begin : watch
        result_t want;
        if (!rst_n) begin
            pk_phase   = PH_IDLE;
            pk_left    = '0;
            pk_iv_len  = 15;
            pk_exp     = '0;
            pk_ofs     = 0;
            pk_dlen    = 0;
            pk_chunk   = '0;
            pk_err     = ERR_OK;
            miss_count = 0;
            expected_labels.delete();
            mismatches     <= 0;
            labels_waiting <= 0;
        end
        else begin
            if (s_tvalid && s_tready)
                expected_labels.insert(expected_labels.size(),
                                       label_byte(s_tdata[7:0], s_tuser[0],
                                                  s_tdata[39:8]));
            if (m_tvalid && m_tready) begin
                if (expected_labels.size() == 0) begin
                    miss_count++;
                    $error("result: expected none, got byte %0d class %0d",
                           m_tdata[7:0], m_tuser[3:0]);
                end
                else begin
                    want = expected_labels.pop_front();
                    check_field("out_byte", want.out_byte, m_tdata[7:0]);
                    check_field("byte_class", want.byte_class, m_tuser[3:0]);
                    check_field("chunk_number", want.chunk_number, m_tdata[33:8]);
                    check_field("chunk_end", want.chunk_end, m_tuser[4]);
                    check_field("packet_end", want.packet_end, m_tlast);
                    check_field("error_code", want.error_code, m_tuser[7:5]);
                end
            end
            mismatches     <= miss_count;
            labels_waiting <= expected_labels.size();
        end
    end

endmodule

// File: verif/tb_aead_packet_chunk_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aead_packet_chunk_deframer
// Feeds directed and random packet bodies, well-formed and broken, into the
// deframer with random idle bursts on both channels; the checker predicts and
// compares every result, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_aead_packet_chunk_deframer
    import acdf_pkg::*;
();

    localparam int RUN_LIMIT  = 200000;
    localparam int RAND_BYTES = 150;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [7:0]  m_tuser;
    logic        m_tlast;

    int gap_odds   = 0;
    int stall_left = 0;
    int bytes_sent = 0;
    int cycles     = 0;
    int mismatches;
    int labels_waiting;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    aead_packet_chunk_deframer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    aead_deframer_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatches     (mismatches),
        .labels_waiting (labels_waiting)
    );

    // Stall the result channel in bursts, at random while gap_odds is set
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            stall_left <= $urandom_range(0, 17);
            m_tready   <= 1'b0;
        end
        else begin
            m_tready <= 1'b1;
        end
    end

    // Give up on a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Hand one body byte over, after an optional idle burst
    task automatic send_byte(input logic [7:0] b, input logic first, input logic [31:0] len);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {len, b};
        s_tuser  <= first;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        bytes_sent++;
    endtask

    // Send count bytes of a body: header octets as given, the rest random.
    // A count below len leaves the body to be cut by the next first byte,
    // a count above len adds bytes outside any packet.
    task automatic send_body(input logic [31:0] len, input logic [7:0] ver,
                             input logic [7:0] cipher, input logic [7:0] aead,
                             input logic [7:0] octet, input int count);
        logic [7:0] b;
        for (int i = 0; i < count; i++) begin
            case (i)
                0:       b = ver;
                1:       b = cipher;
                2:       b = aead;
                3:       b = octet;
                default: b = 8'($urandom);
            endcase
            send_byte(b, i == 0, (i == 0) ? len : $urandom);
        end
    endtask

    initial begin
        int         rand_start;
        int         len;
        int         count;
        logic [7:0] aead;
        logic [7:0] cipher;
        logic [7:0] octet;
        logic [7:0] ver;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: bytes before any packet
        send_byte(8'hFF, 1'b0, 32'hFFFF_FFFF);
        send_byte(8'h00, 1'b0, 32'h0);
        // Zero body length, then a stray byte
        send_body(32'd0, VERSION_V1, CIPHER_A, AEAD_OCB, 8'd0, 2);
        // Too short on the version byte, and for EAX on the aead type byte
        send_body(32'd36, VERSION_V1, CIPHER_A, AEAD_OCB, 8'd0, 5);
        send_body(32'd37, VERSION_V1, CIPHER_B, AEAD_EAX, 8'd0, 4);
        // Bad version, cipher, aead type and chunk octet
        send_body(32'd40, 8'hFF, CIPHER_C, AEAD_OCB, 8'd0, 3);
        send_body(32'd40, 8'h00, CIPHER_C, AEAD_OCB, 8'd0, 2);
        send_body(32'd40, VERSION_V1, 8'd6, AEAD_OCB, 8'd0, 3);
        send_body(32'd40, VERSION_V1, 8'd10, AEAD_OCB, 8'd0, 2);
        send_body(32'd40, VERSION_V1, CIPHER_A, 8'd0, 8'd0, 4);
        send_body(32'd40, VERSION_V1, CIPHER_A, 8'd3, 8'd0, 3);
        send_body(32'd40, VERSION_V1, CIPHER_A, AEAD_OCB, 8'd17, 5);
        send_body(32'd40, VERSION_V1, CIPHER_A, AEAD_OCB, 8'd255, 4);
        // Truncated chunk tag: 20 bytes left at the first chunk start
        send_body(32'd40, VERSION_V1, CIPHER_C, AEAD_EAX, 8'd0, 40);
        // Empty chunk data: exactly one tag before the final tag
        send_body(32'd51, VERSION_V1, CIPHER_B, AEAD_OCB, 8'd16, 51);
        // Two chunks, the second one short, then bytes outside the packet
        send_body(32'd142, VERSION_V1, CIPHER_A, AEAD_EAX, 8'd0, 144);
        // Huge body cut by the next packet
        send_body(32'hFFFF_FFFF, VERSION_V1, CIPHER_C, AEAD_OCB, 8'd16, 30);

        // Random: mostly well-formed bodies, the rest noise and broken ones
        rand_start = bytes_sent;
        while (bytes_sent - rand_start < RAND_BYTES) begin
            if (bytes_sent - rand_start >= RAND_BYTES * 4 / 5)
                gap_odds <= 0;
            else if ($urandom_range(0, 3) == 0)
                gap_odds <= 0;
            else
                gap_odds <= $urandom_range(3, 10);

            if ($urandom_range(0, 9) < 7) begin
                ver  = VERSION_V1;
                aead = $urandom_range(0, 1) ? AEAD_EAX : AEAD_OCB;
                case ($urandom_range(0, 2))
                    0:       cipher = CIPHER_A;
                    1:       cipher = CIPHER_B;
                    default: cipher = CIPHER_C;
                endcase
                octet = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, MAX_CHUNK_OCTET))
                                                    : 8'($urandom_range(0, 1));
                len   = 4 + ((aead == AEAD_EAX) ? 16 : 15) + $urandom_range(18, 150);
                count = len;
                if ($urandom_range(0, 7) == 0)
                    count = len + $urandom_range(1, 3);
                else if ($urandom_range(0, 7) == 0)
                    count = $urandom_range(1, len - 1);
            end
            else begin
                ver    = ($urandom_range(0, 3) == 0) ? 8'($urandom) : VERSION_V1;
                cipher = ($urandom_range(0, 3) == 0) ? 8'($urandom) : CIPHER_B;
                aead   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : AEAD_OCB;
                octet  = 8'($urandom);
                len    = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 80);
                count  = $urandom_range(1, 40);
            end
            // Keep the random part near its byte budget
            if (count > RAND_BYTES - (bytes_sent - rand_start))
                count = RAND_BYTES - (bytes_sent - rand_start);
            send_body(len, ver, cipher, aead, octet, count);
        end

        // Drain: wait for every label, then keep watching for stray results before the verdict
        s_tvalid <= 1'b0;
        gap_odds <= 0;
        @(posedge clk);
        while (labels_waiting != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && labels_waiting == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: aead_packet_chunk_deframer.f
hw/rtl/acdf_pkg.sv
hw/rtl/acdf_classify.sv
hw/rtl/aead_packet_chunk_deframer.sv
verif/aead_deframer_checker.sv
verif/tb_aead_packet_chunk_deframer.sv
